>>> src/sps_pkg.sv
`default_nettype none

package sps_pkg;

    // default prefix capacity in bytes
    localparam int MAX_PREFIX_BYTES_DEF = 64;

    // message characters
    localparam logic [7:0] COLON_CHAR = 8'h3A;
    localparam logic [7:0] ZERO_CHAR  = 8'h30;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    // digest nibble count that difficulty is clamped to
    localparam logic [6:0] MAX_NIBBLES = 7'd64;

    // commands from the controller to the datapath
    typedef struct packed {
        logic       load_item;
        logic       capture;
        logic       conv_start;
        logic       conv_step;
        logic       init_hash;
        logic       round_start;
        logic       ld_issue;
        logic       round_en;
        logic       final_add;
        logic       clear_len;
        logic [3:0] word;
        logic [5:0] round;
    } sps_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic last_block;
        logic pass;
    } sps_stat_t;

    // block index width for a given prefix capacity
    function automatic int sps_blk_w(int max_bytes);
        int nb;
        nb = (max_bytes + 83) / 64;
        return (nb > 1) ? $clog2(nb) : 1;
    endfunction

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] sig0(logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic logic [31:0] bsig0(logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] bsig1(logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    // initial hash value
    function automatic logic [31:0] init_h(logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            default: r = 32'h5be0cd19;
        endcase
        return r;
    endfunction

    // round constants
    function automatic logic [31:0] round_k(logic [5:0] t);
        logic [31:0] r;
        case (t)
            6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
            6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
            6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
            6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
            6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
            6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
            6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
            6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
            6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
            6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
            6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
            6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
            6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
            6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
            6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
            6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
            6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
            6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
            6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
            6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
            6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
            6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
            6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
            6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
            6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
            6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
            6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
            6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
            6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
            6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
            6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
            6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/sps_datapath.sv
`default_nettype none

module sps_datapath import sps_pkg::*; #(
    parameter int MAX_PREFIX_BYTES = MAX_PREFIX_BYTES_DEF,
    parameter int BLK_W            = sps_blk_w(MAX_PREFIX_BYTES)
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire sps_cmd_t         cmd,
    input  wire logic [BLK_W-1:0] blk,
    input  wire logic [15:0]      attempt,
    input  wire logic [7:0]       s_prefix_byte,
    input  wire logic             s_byte_present,
    input  wire logic [31:0]      s_base_number,
    input  wire logic [6:0]       s_difficulty,
    output sps_stat_t             stat
);

    localparam int PW    = (MAX_PREFIX_BYTES + 3) / 4;
    localparam int AW    = (PW > 1) ? $clog2(PW) : 1;
    localparam int CNT_W = $clog2(MAX_PREFIX_BYTES + 1);
    localparam int POS_W = BLK_W + 6;
    localparam int WI_W  = BLK_W + 4;

    // prefix storage, one 32-bit word per four bytes
    logic [3:0][7:0] mem [PW];
    logic [31:0]     mem_q_reg;

    logic [CNT_W-1:0] plen_reg, plen_next;
    logic [31:0]      base_reg;
    logic [6:0]       need_reg;
    logic [31:0]      sh_reg;
    logic [39:0]      bcd_reg;
    logic [31:0]      h_reg [8];
    logic [31:0]      v_reg [8];
    logic [31:0]      win_reg [16];
    logic             ldv_reg;
    logic [3:0]       ldw_reg;

    logic [AW-1:0]    waddr;
    logic [1:0]       wlane;
    logic             wr_en;
    logic [WI_W-1:0]  widx;
    logic [AW-1:0]    raddr;

    // prefix write and length
    always_comb begin
        waddr     = AW'(plen_reg >> 2);
        wlane     = 2'(plen_reg);
        wr_en     = cmd.load_item && s_byte_present &&
                    (32'(plen_reg) < 32'(MAX_PREFIX_BYTES));
        plen_next = plen_reg;
        if (cmd.clear_len) begin
            plen_next = '0;
        end else if (wr_en) begin
            plen_next = plen_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg <= '0;
        end else begin
            plen_reg <= plen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[waddr][wlane] <= s_prefix_byte;
        end
    end

    // word read for the message load
    always_comb begin
        widx  = {blk, cmd.word};
        raddr = '0;
        if (32'(widx) < 32'(PW)) begin
            raddr = AW'(widx);
        end
    end

    always_ff @(posedge aclk) begin
        mem_q_reg <= mem[raddr];
    end

    // search parameters on the final transfer
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            base_reg <= s_base_number;
            need_reg <= (s_difficulty > MAX_NIBBLES) ? MAX_NIBBLES : s_difficulty;
        end
    end

    // binary to decimal by shift and add-3
    always_ff @(posedge aclk) begin
        if (cmd.conv_start) begin
            sh_reg  <= base_reg + {16'd0, attempt};
            bcd_reg <= '0;
        end else if (cmd.conv_step) begin
            logic [39:0] adj;
            for (int k = 0; k < 10; k++) begin
                adj[4*k +: 4] = (bcd_reg[4*k +: 4] >= 4'd5) ?
                                bcd_reg[4*k +: 4] + 4'd3 : bcd_reg[4*k +: 4];
            end
            bcd_reg <= {adj[38:0], sh_reg[31]};
            sh_reg  <= {sh_reg[30:0], 1'b0};
        end
    end

    // digit count and message length
    logic [3:0]       nd;
    logic [POS_W-1:0] plen_p, len_p;
    logic [POS_W:0]   nblk;
    logic             last_blk;
    logic             pass_ok;

    always_comb begin
        nd = 4'd1;
        for (int k = 1; k < 10; k++) begin
            if (bcd_reg[4*k +: 4] != 4'd0) begin
                nd = 4'(k + 1);
            end
        end
        plen_p   = POS_W'(plen_reg);
        len_p    = plen_p + POS_W'(nd) + 1'b1;
        nblk     = ({1'b0, len_p} + (POS_W+1)'(72)) >> 6;
        last_blk = (blk == BLK_W'(nblk - 1'b1));
    end

    // status to the controller
    assign stat = '{last_block: last_blk, pass: pass_ok};

    // message word assembly for the word read last cycle
    logic [31:0]      msg_word;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] didx;
    logic [3:0]       dsel;
    logic [7:0]       mbyte;

    always_comb begin
        msg_word = '0;
        pos      = '0;
        didx     = '0;
        dsel     = '0;
        mbyte    = '0;
        for (int j = 0; j < 4; j++) begin
            pos   = {blk, ldw_reg, 2'(j)};
            didx  = len_p - 1'b1 - pos;
            dsel  = 4'(didx);
            mbyte = 8'd0;
            if (pos < plen_p) begin
                mbyte = mem_q_reg[8*j +: 8];
            end else if (pos == plen_p) begin
                mbyte = COLON_CHAR;
            end else if (pos < len_p) begin
                mbyte = ZERO_CHAR | {4'd0, bcd_reg[4*dsel +: 4]};
            end else if (pos == len_p) begin
                mbyte = PAD_BYTE;
            end
            msg_word[31-8*j -: 8] = mbyte;
        end
        // length field of the final block
        if (last_blk && ldw_reg == 4'd14) begin
            msg_word = '0;
        end else if (last_blk && ldw_reg == 4'd15) begin
            msg_word = 32'({len_p, 3'b000});
        end
    end

    // compression round
    logic [31:0] t1, t2, w_new;

    always_comb begin
        t1 = v_reg[7] + bsig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + round_k(cmd.round) + win_reg[0];
        t2 = bsig0(v_reg[0]) + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^
             (v_reg[1] & v_reg[2]));
        w_new = sig1(win_reg[14]) + win_reg[9] + sig0(win_reg[1]) + win_reg[0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ldv_reg <= 1'b0;
        end else begin
            ldv_reg <= cmd.ld_issue;
        end
    end

    always_ff @(posedge aclk) begin
        ldw_reg <= cmd.word;
    end

    // schedule window
    always_ff @(posedge aclk) begin
        if (ldv_reg || cmd.round_en) begin
            for (int k = 0; k < 15; k++) begin
                win_reg[k] <= win_reg[k+1];
            end
            win_reg[15] <= ldv_reg ? msg_word : w_new;
        end
    end

    // working variables
    always_ff @(posedge aclk) begin
        if (cmd.round_start) begin
            for (int k = 0; k < 8; k++) begin
                v_reg[k] <= h_reg[k];
            end
        end else if (cmd.round_en) begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
    end

    // hash state
    always_ff @(posedge aclk) begin
        if (cmd.init_hash) begin
            for (int k = 0; k < 8; k++) begin
                h_reg[k] <= init_h(3'(k));
            end
        end else if (cmd.final_add) begin
            for (int k = 0; k < 8; k++) begin
                h_reg[k] <= h_reg[k] + v_reg[k];
            end
        end
    end

    // leading zero nibble check
    always_comb begin
        logic fail;
        fail = 1'b0;
        for (int n = 0; n < 64; n++) begin
            if ((7'(n) < need_reg) && (h_reg[n/8][31-4*(n%8) -: 4] != 4'd0)) begin
                fail = 1'b1;
            end
        end
        pass_ok = !fail;
    end

endmodule

`default_nettype wire

>>> src/sps_ctrl.sv
`default_nettype none

module sps_ctrl import sps_pkg::*; #(
    parameter int BLK_W = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    input  wire logic             s_last,
    output logic                  s_ready,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_found,
    output logic [15:0]           m_nonce,
    input  wire logic [15:0]      limit,
    input  wire sps_stat_t        stat,
    output logic [BLK_W-1:0]      blk,
    output logic [15:0]           attempt,
    output sps_cmd_t              cmd
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_START = 8'b0000_0010,
        ST_CONV  = 8'b0000_0100,
        ST_LOAD  = 8'b0000_1000,
        ST_ROUND = 8'b0001_0000,
        ST_FINAL = 8'b0010_0000,
        ST_CHECK = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [15:0]      att_reg, att_next;
    logic [4:0]       bit_reg, bit_next;
    logic [4:0]       wcnt_reg, wcnt_next;
    logic [5:0]       rcnt_reg, rcnt_next;
    logic [BLK_W-1:0] blk_reg, blk_next;
    logic             res_found_reg, res_found_next;
    logic [15:0]      res_nonce_reg, res_nonce_next;
    logic             m_valid_reg, m_valid_next;
    logic             m_found_reg, m_found_next;
    logic [15:0]      m_nonce_reg, m_nonce_next;
    logic             in_xfer;

    assign s_ready = (state_reg == ST_IDLE);
    assign in_xfer = s_valid && s_ready;
    assign blk     = blk_reg;
    assign attempt = att_reg;
    assign m_valid = m_valid_reg;
    assign m_found = m_found_reg;
    assign m_nonce = m_nonce_reg;

    // sequencing of attempts, blocks and rounds
    always_comb begin
        state_next     = state_reg;
        att_next       = att_reg;
        bit_next       = bit_reg;
        wcnt_next      = wcnt_reg;
        rcnt_next      = rcnt_reg;
        blk_next       = blk_reg;
        res_found_next = res_found_reg;
        res_nonce_next = res_nonce_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_found_next   = m_found_reg;
        m_nonce_next   = m_nonce_reg;
        cmd            = '0;
        cmd.word       = wcnt_reg[3:0];
        cmd.round      = rcnt_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    cmd.load_item = 1'b1;
                    cmd.capture   = s_last;
                    if (s_last) begin
                        att_next   = '0;
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                if (limit == 16'd0) begin
                    res_found_next = 1'b0;
                    res_nonce_next = '0;
                    state_next     = ST_DONE;
                end else begin
                    cmd.conv_start = 1'b1;
                    bit_next       = '0;
                    state_next     = ST_CONV;
                end
            end
            ST_CONV: begin
                cmd.conv_step = 1'b1;
                bit_next      = bit_reg + 1'b1;
                if (bit_reg == 5'd31) begin
                    cmd.init_hash = 1'b1;
                    blk_next      = '0;
                    wcnt_next     = '0;
                    state_next    = ST_LOAD;
                end
            end
            ST_LOAD: begin
                cmd.round_start = (wcnt_reg == 5'd0);
                cmd.ld_issue    = !wcnt_reg[4];
                wcnt_next       = wcnt_reg + 1'b1;
                if (wcnt_reg[4]) begin
                    rcnt_next  = '0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND: begin
                cmd.round_en = 1'b1;
                rcnt_next    = rcnt_reg + 1'b1;
                if (rcnt_reg == 6'd63) begin
                    state_next = ST_FINAL;
                end
            end
            ST_FINAL: begin
                cmd.final_add = 1'b1;
                if (stat.last_block) begin
                    state_next = ST_CHECK;
                end else begin
                    blk_next   = blk_reg + 1'b1;
                    wcnt_next  = '0;
                    state_next = ST_LOAD;
                end
            end
            ST_CHECK: begin
                if (stat.pass) begin
                    res_found_next = 1'b1;
                    res_nonce_next = att_reg;
                    state_next     = ST_DONE;
                end else if ({1'b0, att_reg} + 17'd1 == {1'b0, limit}) begin
                    res_found_next = 1'b0;
                    res_nonce_next = '0;
                    state_next     = ST_DONE;
                end else begin
                    att_next   = att_reg + 1'b1;
                    state_next = ST_START;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_found_next  = res_found_reg;
                    m_nonce_next  = res_nonce_reg;
                    cmd.clear_len = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            att_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            att_reg     <= att_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bit_reg       <= bit_next;
        wcnt_reg      <= wcnt_next;
        rcnt_reg      <= rcnt_next;
        blk_reg       <= blk_next;
        res_found_reg <= res_found_next;
        res_nonce_reg <= res_nonce_next;
        m_found_reg   <= m_found_next;
        m_nonce_reg   <= m_nonce_next;
    end

endmodule

`default_nettype wire

>>> src/sha256_pow_nonce_search.sv
// Proof-of-work nonce search over SHA-256 of "prefix:decimal".
// Input channel (s_*): each transfer appends s_prefix_byte to the challenge
// prefix when s_byte_present is set; bytes beyond MAX_PREFIX_BYTES are dropped.
// A transfer with s_last set also takes s_base_number and s_difficulty and
// starts the search; s_ready stays low until the search has finished.
// Loading transfers are taken one per cycle while the block is idle.
// Result channel (m_*): one transfer per search with m_found and m_nonce,
// the first offset whose digest has the required leading zero nibbles.
// Each attempt converts base plus offset to decimal, then runs the B 64-byte
// blocks of the message (1 for prefixes up to 44 bytes) through the single
// shared round unit, one round per cycle; the decimal converter works by
// shift and add. Attempts run one after another; an attempt limit of zero
// answers with m_found low without trying any offset. The result sits in an
// output register, so a stalled receiver does not stop loading or the next
// search; only a second result waits in the final state until the first one
// is taken. APB register 0 (attempt_limit) resets to 65535; the user must
// write it only while idle, and the block itself does not enforce this.
// Reset clears control state and the prefix length; no memory sweep is needed.
`default_nettype none

module sha256_pow_nonce_search import sps_pkg::*; #(
    parameter int MAX_PREFIX_BYTES = MAX_PREFIX_BYTES_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_prefix_byte,
    input  wire logic        s_byte_present,
    input  wire logic        s_last,
    input  wire logic [31:0] s_base_number,
    input  wire logic [6:0]  s_difficulty,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_found,
    output logic [15:0]      m_nonce
);

    localparam int BLK_W = sps_blk_w(MAX_PREFIX_BYTES);

    logic [15:0]      limit_reg;
    sps_cmd_t         cmd;
    sps_stat_t        stat;
    logic [BLK_W-1:0] blk;
    logic [15:0]      attempt;

    // attempt limit register
    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {16'd0, limit_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= 16'hFFFF;
        end else if (psel && penable && pwrite && paddr == 3'd0) begin
            limit_reg <= pwdata[15:0];
        end
    end

    sps_ctrl #(
        .BLK_W (BLK_W)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_last),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_found (m_found),
        .m_nonce (m_nonce),
        .limit   (limit_reg),
        .stat    (stat),
        .blk     (blk),
        .attempt (attempt),
        .cmd     (cmd)
    );

    sps_datapath #(
        .MAX_PREFIX_BYTES (MAX_PREFIX_BYTES),
        .BLK_W            (BLK_W)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .blk            (blk),
        .attempt        (attempt),
        .s_prefix_byte  (s_prefix_byte),
        .s_byte_present (s_byte_present),
        .s_base_number  (s_base_number),
        .s_difficulty   (s_difficulty),
        .stat           (stat)
    );

endmodule

`default_nettype wire

>>> tb/sha256_pow_nonce_search_test.sv
`default_nettype none

module sha256_pow_nonce_search_test;
    import sps_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] ATTEMPT_LIMIT_ADDR = 3'd0;
    localparam int PREFIX_CAP = 64;
    localparam int TARGET_ITEMS = 1550;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int QUIET_FROM = 20000;
    localparam int QUIET_TO = 60000;
    localparam logic [7:0] COLON = 8'h3A;

    typedef struct packed {
        logic [7:0]  prefix_byte;
        logic        byte_present;
        logic        last;
        logic [31:0] base_number;
        logic [6:0]  difficulty;
    } load_item_t;

    typedef struct packed {
        logic        found;
        logic [15:0] nonce;
    } search_result_t;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };
    localparam logic [31:0] H_START [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_prefix_byte;
    logic        s_byte_present;
    logic        s_last;
    logic [31:0] s_base_number;
    logic [6:0]  s_difficulty;
    logic        m_valid;
    logic        m_ready;
    logic        m_found;
    logic [15:0] m_nonce;

    load_item_t     pending_items[$];
    search_result_t expected_results[$];
    int             cycle_count;
    int             error_count;
    int             items_queued;

    // predictor state
    logic [7:0]  challenge_text[PREFIX_CAP];
    int          challenge_len;
    logic [15:0] limit_setting;

    sha256_pow_nonce_search DUT (
        .aclk(aclk), .aresetn(aresetn),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_valid(s_valid), .s_ready(s_ready), .s_prefix_byte(s_prefix_byte),
        .s_byte_present(s_byte_present), .s_last(s_last),
        .s_base_number(s_base_number), .s_difficulty(s_difficulty),
        .m_valid(m_valid), .m_ready(m_ready), .m_found(m_found), .m_nonce(m_nonce)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    // digest of "challenge:decimal(number)"
    function automatic logic [255:0] attempt_digest(logic [31:0] number);
        logic [7:0]  msg[192];
        logic [31:0] w[64];
        logic [31:0] h[8];
        logic [31:0] a, b, c, d, e, f, g, hh, t1, t2;
        logic [63:0] bit_len;
        string       digits;
        int          len, nblk;
        len = challenge_len;
        digits = $sformatf("%0d", number);
        foreach (msg[k]) msg[k] = 8'h00;
        for (int k = 0; k < challenge_len; k++) msg[k] = challenge_text[k];
        msg[len++] = COLON;
        for (int k = 0; k < digits.len(); k++) msg[len++] = digits[k];
        nblk = (len + 9 + 63) / 64;
        bit_len = 64'(len) * 8;
        msg[len] = 8'h80;
        for (int k = 0; k < 8; k++) msg[nblk * 64 - 1 - k] = bit_len[8 * k +: 8];
        for (int k = 0; k < 8; k++) h[k] = H_START[k];
        for (int blk = 0; blk < nblk; blk++) begin
            for (int t = 0; t < 16; t++)
                w[t] = {msg[blk*64+4*t], msg[blk*64+4*t+1], msg[blk*64+4*t+2],
                        msg[blk*64+4*t+3]};
            for (int t = 16; t < 64; t++)
                w[t] = w[t-16] + (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3))
                     + w[t-7] + (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10));
            {a, b, c, d, e, f, g, hh} = {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
            for (int t = 0; t < 64; t++) begin
                t1 = hh + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
                   + ROUND_K[t] + w[t];
                t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                hh = g; g = f; f = e; e = d + t1;
                d = c; c = b; b = a; a = t1 + t2;
            end
            h[0] += a; h[1] += b; h[2] += c; h[3] += d;
            h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
        end
        return {h[0], h[1], h[2], h[3], h[4], h[5], h[6], h[7]};
    endfunction

    // absorb one accepted load item, returns 1 with the search outcome on the last one
    function automatic bit absorb_item(load_item_t it, output search_result_t res);
        logic [255:0] dg;
        int           need;
        bit           hit;
        res = '0;
        if (it.byte_present && challenge_len < PREFIX_CAP)
            challenge_text[challenge_len++] = it.prefix_byte;
        if (!it.last)
            return 1'b0;
        need = (it.difficulty > 64) ? 64 : it.difficulty;
        for (int i = 0; i < limit_setting && !res.found; i++) begin
            dg = attempt_digest(it.base_number + 32'(i));
            hit = 1'b1;
            for (int n = 0; n < need; n++)
                if (dg[255 - 4 * n -: 4] != 4'h0) hit = 1'b0;
            if (hit) begin
                res.found = 1'b1;
                res.nonce = 16'(i);
            end
        end
        challenge_len = 0;
        return 1'b1;
    endfunction

    function automatic bit quiet_stretch();
        return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
    endfunction

    // cycle counter and timeout
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t timeout", $time);
            $display("sha256_pow_nonce_search_test NOT OK");
            $finish;
        end
    end

    // load channel driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (pending_items.size() > 0 && (quiet_stretch() || $urandom_range(0, 99) >= 26)) begin
                load_item_t it;
                it = pending_items.pop_front();
                s_valid <= 1'b1;
                s_prefix_byte <= it.prefix_byte;
                s_byte_present <= it.byte_present;
                s_last <= it.last;
                s_base_number <= it.base_number;
                s_difficulty <= it.difficulty;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result channel back-pressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= quiet_stretch() || $urandom_range(0, 99) >= 26;
    end

    // predict on each accepted load transfer
    always @(posedge aclk) begin
        search_result_t res;
        if (aresetn && s_valid && s_ready) begin
            if (absorb_item({s_prefix_byte, s_byte_present, s_last, s_base_number,
                             s_difficulty}, res))
                expected_results.push_back(res);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge aclk) begin
        search_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                $display("%0t unexpected result found=%0b nonce=%0d", $time, m_found, m_nonce);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_found !== want.found) begin
                    $display("%0t found mismatch: expected %0b actual %0b",
                             $time, want.found, m_found);
                    error_count++;
                end
                if (m_nonce !== want.nonce) begin
                    $display("%0t nonce mismatch: expected %0d actual %0d",
                             $time, want.nonce, m_nonce);
                    error_count++;
                end
            end
        end
    end

    task automatic write_limit(logic [15:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ATTEMPT_LIMIT_ADDR;
        pwdata <= {16'h0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        limit_setting = value;
    endtask

    // wait until the block has drained, then let it settle
    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic queue_item(logic [7:0] b, logic present, logic fin,
                              logic [31:0] base, logic [6:0] diff);
        pending_items.push_back('{b, present, fin, base, diff});
        items_queued++;
    endtask

    // one challenge of nbytes load transfers with random text
    task automatic queue_challenge(int nbytes, logic [31:0] base, logic [6:0] diff);
        logic [7:0] b;
        for (int k = 0; k < nbytes; k++) begin
            b = ($urandom_range(0, 9) == 0) ? COLON : 8'($urandom);
            queue_item(b, $urandom_range(0, 9) != 0, k == nbytes - 1,
                       (k == nbytes - 1) ? $urandom : 32'($urandom),
                       (k == nbytes - 1) ? diff : 7'($urandom));
        end
    endtask

    function automatic logic [6:0] pick_difficulty(logic [15:0] lim);
        int r;
        r = $urandom_range(0, 9);
        if (lim > 32) return 7'($urandom_range(0, 1));
        if (r < 3) return 7'd0;
        if (r < 6) return 7'd1;
        if (r < 8) return 7'd2;
        return 7'($urandom_range(64, 127));
    endfunction

    initial begin
        logic [15:0] lim;
        int          r, nbytes;
        aresetn = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        s_valid = 1'b0; s_prefix_byte = '0; s_byte_present = 1'b0; s_last = 1'b0;
        s_base_number = '0; s_difficulty = '0; m_ready = 1'b0;
        cycle_count = 0; error_count = 0; items_queued = 0;
        challenge_len = 0; limit_setting = 16'hFFFF;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // reset limit: difficulty zero passes at once, empty prefix, top base
        queue_item(8'h00, 1'b0, 1'b1, 32'h0, 7'd0);
        queue_item(8'hAB, 1'b0, 1'b1, 32'hFFFFFFFF, 7'd0);
        queue_item(8'hFF, 1'b1, 1'b0, 32'h0, 7'd0);
        queue_item(8'h00, 1'b1, 1'b1, 32'hFFFFFFFF, 7'd1);
        wait_drained();

        // limit of one, colons in the prefix, clamped and full difficulty
        write_limit(16'd1);
        queue_item(COLON, 1'b1, 1'b0, 32'h0, 7'd0);
        queue_item(COLON, 1'b1, 1'b1, 32'd12345, 7'd0);
        queue_item(8'h41, 1'b1, 1'b1, 32'd7, 7'd64);
        wait_drained();
        write_limit(16'd3);
        queue_item(8'h7F, 1'b1, 1'b0, 32'h0, 7'd0);
        queue_item(8'h80, 1'b1, 1'b1, 32'hFFFFFFFE, 7'd127);
        queue_item(8'h31, 1'b1, 1'b1, 32'd99, 7'd2);
        wait_drained();

        // limit zero tries nothing
        write_limit(16'd0);
        queue_item(8'h55, 1'b1, 1'b1, 32'h0, 7'd0);
        queue_item(8'hAA, 1'b1, 1'b1, 32'h80000000, 7'd1);
        wait_drained();

        // random phases, each under its own limit
        while (items_queued < TARGET_ITEMS) begin
            r = $urandom_range(0, 9);
            lim = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : (r == 2) ? 16'd1
                : 16'($urandom_range(2, 24));
            write_limit(lim);
            repeat ($urandom_range(3, 7)) begin
                nbytes = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 80)
                                                      : $urandom_range(1, 20);
                queue_challenge(nbytes, $urandom, pick_difficulty(lim));
            end
            wait_drained();
        end

        if (error_count == 0) begin
            $display("sha256_pow_nonce_search_test OK");
        end else begin
            $display("sha256_pow_nonce_search_test NOT OK");
        end
        $finish;
    end

endmodule

`default_nettype wire
